// File: rtl/tftp_pkg.sv
// Shared types and constants of the TFTP download receiver.
// Used by the channel interfaces, the register block and the top level.
package tftp_pkg;

	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned ADDR_W      = 6;
	localparam int unsigned DATA_W      = 64;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_ARP_REQ = 3'd1;
	localparam logic [2:0] KIND_ARP_REP = 3'd2;
	localparam logic [2:0] KIND_RRQ     = 3'd3;
	localparam logic [2:0] KIND_ACK     = 3'd4;

	localparam logic [1:0] STATUS_IDLE = 2'd0;
	localparam logic [1:0] STATUS_XFER = 2'd1;
	localparam logic [1:0] STATUS_DONE = 2'd2;
	localparam logic [1:0] STATUS_TOUT = 2'd3;

	localparam logic [15:0] ETH_IP       = 16'h0800;
	localparam logic [15:0] ETH_ARP      = 16'h0806;
	localparam logic [15:0] ARP_OP_REQ   = 16'd1;
	localparam logic [15:0] ARP_OP_REP   = 16'd2;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] TFTP_DATA    = 16'd3;
	localparam logic [15:0] TFTP_PORT    = 16'd69;
	localparam logic [15:0] UDP_HDR_LEN  = 16'd12;

	localparam logic [2:0] REG_LOCAL_IP      = 3'd0;
	localparam logic [2:0] REG_SERVER_IP     = 3'd1;
	localparam logic [2:0] REG_LOCAL_MAC     = 3'd2;
	localparam logic [2:0] REG_LOCAL_PORT    = 3'd3;
	localparam logic [2:0] REG_DOWNLOAD_BASE = 3'd4;
	localparam logic [2:0] REG_RETRY_LIMIT   = 3'd5;
	localparam logic [2:0] REG_RETRY_SECONDS = 3'd6;

	localparam logic [15:0] LOCAL_PORT_RST    = 16'h8003;
	localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd10;
	localparam logic [4:0]  RETRY_SECONDS_RST = 5'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] ether_type;
		logic [15:0] arp_operation;
		logic [31:0] arp_src_ip;
		logic [47:0] arp_src_mac;
		logic [7:0]  ip_protocol;
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [15:0] tftp_opcode;
		logic [15:0] block_number;
		logic [15:0] udp_length;
	} tftp_in_t;

	typedef struct packed {
		logic [2:0]  send_kind;
		logic [15:0] ack_block;
		logic        store_enable;
		logic [31:0] store_address;
		logic [15:0] store_length;
		logic [47:0] server_mac;
		logic [15:0] server_port;
		logic [1:0]  status;
	} tftp_out_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] server_ip;
		logic [47:0] local_mac;
		logic [15:0] local_port;
		logic [31:0] download_base;
		logic [3:0]  retry_limit;
		logic [4:0]  retry_seconds;
		logic        forget_mac;
	} tftp_cfg_t;

endpackage

// File: rtl/tftp_in_if.sv
// Input channel of the TFTP download receiver: one beat per frame header,
// tick or start. Depends on tftp_pkg.
interface tftp_in_if;
	import tftp_pkg::*;

	logic     valid;
	logic     ready;
	tftp_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/tftp_out_if.sv
// Result channel of the TFTP download receiver: one beat per input beat.
// Depends on tftp_pkg.
interface tftp_out_if;
	import tftp_pkg::*;

	logic      valid;
	logic      ready;
	tftp_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/tftp_regs.sv
// APB-style configuration registers of the TFTP download receiver.
// Depends on tftp_pkg; drives the register struct used by the top level.
module tftp_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tftp_pkg::ADDR_W-1:0]      paddr,
	input  logic [tftp_pkg::DATA_W-1:0]      pwdata,
	output logic [tftp_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	output tftp_pkg::tftp_cfg_t              cfg
);
	import tftp_pkg::*;

	logic        wr_en;
	logic [2:0]  reg_idx;
	logic [31:0] local_ip_q;
	logic [31:0] server_ip_q;
	logic [47:0] local_mac_q;
	logic [15:0] local_port_q;
	logic [31:0] download_base_q;
	logic [3:0]  retry_limit_q;
	logic [4:0]  retry_seconds_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q      <= '0;
			server_ip_q     <= '0;
			local_mac_q     <= '0;
			local_port_q    <= LOCAL_PORT_RST;
			download_base_q <= '0;
			retry_limit_q   <= RETRY_LIMIT_RST;
			retry_seconds_q <= RETRY_SECONDS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LOCAL_IP:      local_ip_q      <= pwdata[31:0];
				REG_SERVER_IP:     server_ip_q     <= pwdata[31:0];
				REG_LOCAL_MAC:     local_mac_q     <= pwdata[47:0];
				REG_LOCAL_PORT:    local_port_q    <= pwdata[15:0];
				REG_DOWNLOAD_BASE: download_base_q <= pwdata[31:0];
				REG_RETRY_LIMIT:   retry_limit_q   <= pwdata[3:0];
				REG_RETRY_SECONDS: retry_seconds_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOCAL_IP:      prdata = {32'd0, local_ip_q};
			REG_SERVER_IP:     prdata = {32'd0, server_ip_q};
			REG_LOCAL_MAC:     prdata = {16'd0, local_mac_q};
			REG_LOCAL_PORT:    prdata = {48'd0, local_port_q};
			REG_DOWNLOAD_BASE: prdata = {32'd0, download_base_q};
			REG_RETRY_LIMIT:   prdata = {60'd0, retry_limit_q};
			REG_RETRY_SECONDS: prdata = {59'd0, retry_seconds_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.local_ip      = local_ip_q;
	assign cfg.server_ip     = server_ip_q;
	assign cfg.local_mac     = local_mac_q;
	assign cfg.local_port    = local_port_q;
	assign cfg.download_base = download_base_q;
	assign cfg.retry_limit   = retry_limit_q;
	assign cfg.retry_seconds = retry_seconds_q;
	assign cfg.forget_mac    = wr_en &
		((reg_idx == REG_LOCAL_IP) || (reg_idx == REG_SERVER_IP));

endmodule

// File: rtl/tftp_download_receiver.sv
// TFTP download receiver top level: input register, transfer engine and
// result register. Depends on tftp_pkg, tftp_in_if, tftp_out_if, tftp_regs.
//
// Usage: each beat on the item channel is a start command, a one-second
// tick or the decoded header of one received Ethernet frame. Every item
// yields exactly one beat on the result channel, in order, telling the
// frame builder what to send (ARP request or reply, read request, ACK)
// and the store datapath where to write the data bytes of a block.
// Configuration is written through the APB-style port while no item is
// in flight; writing either IP address forgets the learned server MAC.
// The item is registered in the input register at acceptance; the engine
// then updates its state and loads the result register once that register
// is free, and the result beat is shown from there. One item is taken
// every cycle while the result side does not stall.
// When the result side stalls, the result register holds its beat and
// the input register holds one more item; item.ready then falls.
// Reset clears the pipeline and puts the engine in the idle phase with
// no server MAC known and server port 69; registers take their defaults.
module tftp_download_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	tftp_in_if.sink                     item,
	tftp_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tftp_pkg::ADDR_W-1:0] paddr,
	input  logic [tftp_pkg::DATA_W-1:0] pwdata,
	output logic [tftp_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import tftp_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_XFER = 4'b0010,
		PH_DONE = 4'b0100,
		PH_TOUT = 4'b1000
	} phase_t;

	tftp_cfg_t   cfg;
	logic        v_s1;
	tftp_in_t    in_s1;
	logic        v_s2;
	tftp_out_t   out_s2;
	logic        adv;
	logic        proc;

	logic        mac_known_q;
	logic [47:0] learned_mac_q;
	logic [15:0] peer_port_q;
	phase_t      phase_q;
	logic        awaiting_first_q;
	logic [15:0] acked_block_q;
	logic [31:0] bytes_stored_q;
	logic [3:0]  retries_left_q;
	logic [4:0]  seconds_left_q;

	logic        mac_known_d;
	logic [47:0] learned_mac_d;
	logic [15:0] peer_port_d;
	phase_t      phase_d;
	logic        awaiting_first_d;
	logic [15:0] acked_block_d;
	logic [31:0] bytes_stored_d;
	logic [3:0]  retries_left_d;
	logic [4:0]  seconds_left_d;
	tftp_out_t   out_d;

	logic [3:0]  limit_eff;
	logic [4:0]  secs_eff;
	logic [4:0]  secs_dec;
	logic [3:0]  retries_dec;
	logic        data_frame;
	logic        port_ok;
	logic [15:0] base_block;
	logic [15:0] data_len;

	tftp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv        = !v_s2 || result.ready;
	assign proc       = v_s1 && adv;
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				v_s1 <= item.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			in_s1 <= item.data;
		end
		if (proc) begin
			out_s2 <= out_d;
		end
	end

	assign result.valid = v_s2;
	assign result.data  = out_s2;

	assign limit_eff   = (cfg.retry_limit == 4'd0) ? 4'd1 : cfg.retry_limit;
	assign secs_eff    = (cfg.retry_seconds == 5'd0) ? 5'd1 : cfg.retry_seconds;
	assign secs_dec    = seconds_left_q - 5'd1;
	assign retries_dec = retries_left_q - 4'd1;
	assign data_len    = in_s1.udp_length - UDP_HDR_LEN;
	assign data_frame  = (in_s1.ether_type == ETH_IP) && (phase_q == PH_XFER) &&
		(in_s1.ip_protocol == PROTO_UDP) && (in_s1.dest_port == cfg.local_port) &&
		(in_s1.tftp_opcode == TFTP_DATA) && (in_s1.udp_length >= UDP_HDR_LEN);
	assign port_ok     = awaiting_first_q ? (in_s1.block_number == 16'd1)
		: (in_s1.source_port == peer_port_q);
	assign base_block  = awaiting_first_q ? 16'd0 : acked_block_q;

	always_comb begin
		mac_known_d      = mac_known_q;
		learned_mac_d    = learned_mac_q;
		peer_port_d      = peer_port_q;
		phase_d          = phase_q;
		awaiting_first_d = awaiting_first_q;
		acked_block_d    = acked_block_q;
		bytes_stored_d   = bytes_stored_q;
		retries_left_d   = retries_left_q;
		seconds_left_d   = seconds_left_q;
		out_d            = '0;
		unique case (in_s1.op)
			OP_START: begin
				out_d.send_kind  = KIND_ARP_REQ;
				bytes_stored_d   = '0;
				acked_block_d    = '0;
				awaiting_first_d = 1'b1;
				peer_port_d      = TFTP_PORT;
				phase_d          = PH_XFER;
				retries_left_d   = limit_eff;
				seconds_left_d   = secs_eff;
			end
			OP_TICK: begin
				if (phase_q == PH_XFER) begin
					seconds_left_d = secs_dec;
					if (secs_dec == 5'd0) begin
						retries_left_d = retries_dec;
						seconds_left_d = secs_eff;
						if (!mac_known_q) begin
							out_d.send_kind = KIND_ARP_REQ;
						end else if (awaiting_first_q) begin
							out_d.send_kind = KIND_RRQ;
						end else begin
							out_d.send_kind = KIND_ACK;
							out_d.ack_block = acked_block_q;
						end
						if (retries_dec == 4'd0) begin
							phase_d = PH_TOUT;
						end
					end
				end
			end
			OP_FRAME: begin
				if (phase_q == PH_XFER) begin
					retries_left_d = limit_eff;
					seconds_left_d = secs_eff;
				end
				if (in_s1.ether_type == ETH_ARP) begin
					if (in_s1.arp_operation == ARP_OP_REP) begin
						if (!mac_known_q && (in_s1.arp_src_ip == cfg.server_ip)) begin
							mac_known_d   = 1'b1;
							learned_mac_d = in_s1.arp_src_mac;
						end
					end else if (in_s1.arp_operation == ARP_OP_REQ) begin
						out_d.send_kind = KIND_ARP_REP;
					end
				end else if (data_frame && port_ok) begin
					if (awaiting_first_q) begin
						peer_port_d      = in_s1.source_port;
						awaiting_first_d = 1'b0;
						acked_block_d    = '0;
					end
					if (in_s1.block_number == base_block + 16'd1) begin
						acked_block_d       = in_s1.block_number;
						out_d.store_enable  = 1'b1;
						out_d.store_address = cfg.download_base + bytes_stored_q;
						out_d.store_length  = data_len;
						bytes_stored_d      = bytes_stored_q + {16'd0, data_len};
					end
					out_d.send_kind = KIND_ACK;
					out_d.ack_block = acked_block_d;
					if (data_len < 16'(BLOCK_BYTES)) begin
						phase_d = PH_DONE;
					end
				end
			end
			default: ;
		endcase
		out_d.server_mac  = mac_known_d ? learned_mac_d : '0;
		out_d.server_port = peer_port_d;
		unique case (phase_d)
			PH_IDLE: out_d.status = STATUS_IDLE;
			PH_XFER: out_d.status = STATUS_XFER;
			PH_DONE: out_d.status = STATUS_DONE;
			PH_TOUT: out_d.status = STATUS_TOUT;
			default: out_d.status = STATUS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_known_q      <= 1'b0;
			learned_mac_q    <= '0;
			peer_port_q      <= TFTP_PORT;
			phase_q          <= PH_IDLE;
			awaiting_first_q <= 1'b1;
			acked_block_q    <= '0;
			bytes_stored_q   <= '0;
			retries_left_q   <= '0;
			seconds_left_q   <= '0;
		end else begin
			if (proc) begin
				mac_known_q      <= mac_known_d & ~cfg.forget_mac;
				learned_mac_q    <= learned_mac_d;
				peer_port_q      <= peer_port_d;
				phase_q          <= phase_d;
				awaiting_first_q <= awaiting_first_d;
				acked_block_q    <= acked_block_d;
				bytes_stored_q   <= bytes_stored_d;
				retries_left_q   <= retries_left_d;
				seconds_left_q   <= seconds_left_d;
			end else if (cfg.forget_mac) begin
				mac_known_q <= 1'b0;
			end
		end
	end

	a_store_is_acked: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.store_enable |-> result.data.send_kind == KIND_ACK)
		else $error("store beat without an ACK");

	a_ack_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.send_kind != KIND_ACK) |-> result.data.ack_block == 16'd0)
		else $error("ACK block set on a beat that sends no ACK");

	a_timeout_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TOUT) && !(proc && (in_s1.op == OP_START)) |=> phase_q == PH_TOUT)
		else $error("timed-out transfer left without a start");

	a_stored_block_acked: assert property (@(posedge clk) disable iff (!arst_n)
		proc && out_d.store_enable |=> acked_block_q == $past(in_s1.block_number))
		else $error("stored block not recorded as acknowledged");

	a_mac_from_arp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mac_known_q) |-> $past(proc && (in_s1.ether_type == ETH_ARP)))
		else $error("server MAC learned without an ARP beat");

endmodule
